@@ design/bvm_pkg.sv @@
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared types, widths and constants of the battery voltage and charge
// monitor: payload structs, serial unit requests, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package bvm_pkg;

	// Field widths
	localparam int ADC_W      = 12;
	localparam int STAMP_W    = 32;
	localparam int MC_W       = 14;
	localparam int MV_W       = 16;
	localparam int MA_W       = 16;
	localparam int MAH_W      = 16;
	localparam int CELL_W     = 4;
	localparam int WEIGHT_W   = 8;
	localparam int MCOUNT_W   = 4;
	localparam int ACC_W      = 48;
	localparam int CSUM_W     = 18;
	localparam int CPROD_W    = 20;

	// Motor inputs carried by one item, and default for the used count
	localparam int NUM_MOTOR_IN   = 8;
	localparam int MAX_MOTORS_DEF = 8;

	// Scaling and charge constants
	localparam int unsigned SCALE_NUM = 2420;
	localparam int unsigned SCALE_DEN = 273;
	localparam int unsigned MAH_MAMS  = 3600000;
	localparam int unsigned CELL_TOP  = 15;

	// Serial multiplier: a (up to 32 bits) times b (up to 16 bits)
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Serial divider: 24-bit dividend, 9-bit divisor
	localparam int DIV_N_W = 24;
	localparam int DIV_D_W = 9;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FILTER_WEIGHT   = 3'd0,
		CFG_MAX_CELL_MV     = 3'd1,
		CFG_MIN_CELL_MV     = 3'd2,
		CFG_IDLE_CURRENT_MA = 3'd3,
		CFG_MOTOR_COUNT     = 3'd4
	} cfg_idx_t;

	// Register reset values
	localparam logic [WEIGHT_W-1:0] RST_FILTER_WEIGHT   = 8'd7;
	localparam logic [MV_W-1:0]     RST_MAX_CELL_MV     = 16'd4200;
	localparam logic [MV_W-1:0]     RST_MIN_CELL_MV     = 16'd3300;
	localparam logic [MA_W-1:0]     RST_IDLE_CURRENT_MA = 16'd300;
	localparam logic [MCOUNT_W-1:0] RST_MOTOR_COUNT     = 4'd4;

	typedef struct packed {
		logic              func;
		logic [ADC_W-1:0]  adc_raw;
		logic [STAMP_W-1:0] now_ms;
		logic [MC_W-1:0]   motor_current_0;
		logic [MC_W-1:0]   motor_current_1;
		logic [MC_W-1:0]   motor_current_2;
		logic [MC_W-1:0]   motor_current_3;
		logic [MC_W-1:0]   motor_current_4;
		logic [MC_W-1:0]   motor_current_5;
		logic [MC_W-1:0]   motor_current_6;
		logic [MC_W-1:0]   motor_current_7;
	} item_t;

	typedef struct packed {
		logic [MV_W-1:0]   voltage_mv;
		logic [MA_W-1:0]   current_ma;
		logic [MAH_W-1:0]  used_mah;
		logic [CELL_W-1:0] cell_count;
		logic              low_battery;
	} result_t;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

endpackage

`default_nettype wire

@@ design/battery_voltage_and_charge_monitor.sv @@
// ----------------------------------------------------------------------------
// battery_voltage_and_charge_monitor
// Battery voltage filter, current sum, charge counter and cell detection.
// ----------------------------------------------------------------------------
// Use:
//   item channel (item_valid/item_stall, payload item) carries one request:
//   func 0 is a measurement update, func 1 recomputes the cell count.
//   result channel (result_valid/result_stall, payload result) returns one
//   result per request. cfg channel (cfg_valid/cfg_ready, always ready)
//   writes a register by index; write only while the block is idle.
// Flow:
//   An update runs a serial multiply of the ADC sample, two divisions of
//   24-bit dividends in the shared serial divider (scaling and filter),
//   the charge multiply (overlapped with the first division) and a short
//   multiply for the low-battery threshold.
//   The filter and threshold multiplies grow with the bit length of
//   filter_weight and of the cell count.
//   A cell-count request scans the candidate counts 0 to 15, then runs
//   the threshold multiply.
//   One request is worked on at a time; item_stall is high from the cycle
//   after a transfer until the result has gone to the output register.
// Reset: all state and registers go to their reset values, no result valid.
// Stall: a waiting result holds in the output register; the next request
//   is still taken and worked on, and waits at the end until the register
//   frees.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_voltage_and_charge_monitor import bvm_pkg::*; #(
	parameter int MAX_MOTORS = MAX_MOTORS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire item_t                 item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int KW     = $clog2(MAX_MOTORS + 1);
	localparam int MIDX_W = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE,
		ST_SCALE_W,
		ST_CHG_W,
		ST_ACC,
		ST_MAH,
		ST_FMUL_W,
		ST_FDIV_W,
		ST_CELL,
		ST_LOW,
		ST_LOW_W
	} state_t;

	// Configuration registers
	logic [WEIGHT_W-1:0] filter_weight_q;
	logic [MV_W-1:0]     max_cell_q;
	logic [MV_W-1:0]     min_cell_q;
	logic [MA_W-1:0]     idle_q;
	logic [MCOUNT_W-1:0] motor_count_q;

	// Monitor state
	state_t              state_q;
	item_t               item_q;
	logic [MV_W-1:0]     filtered_q;
	logic [CELL_W-1:0]   cells_q;
	logic [STAMP_W-1:0]  last_stamp_q;
	logic [ACC_W-1:0]    acc_q;
	logic [MAH_W-1:0]    used_q;
	logic [MA_W-1:0]     last_cur_q;

	// Work registers
	logic [CSUM_W-1:0]   sum_q;
	logic [KW-1:0]       k_q;
	logic [MV_W-1:0]     sample_q;
	logic [ACC_W-1:0]    add_q;
	logic [CELL_W-1:0]   j_q;
	logic [CPROD_W-1:0]  cprod_q;
	logic                out_valid_q;
	result_t             result_q;

	// Serial units
	mul_req_t            mul_req;
	logic                mul_busy;
	logic [MUL_P_W-1:0]  mul_p;
	div_req_t            div_req;
	logic                div_busy;
	logic [DIV_N_W-1:0]  div_q;

	logic [MC_W-1:0]     motor_all [NUM_MOTOR_IN];
	logic [MC_W-1:0]     motor_arr [MAX_MOTORS];
	logic [KW-1:0]       lim;
	logic                sum_done;
	logic [MA_W-1:0]     cur_sat;
	logic [STAMP_W-1:0]  elapsed;
	logic [ACC_W:0]      acc_sum;
	logic                cell_more;
	logic                out_free;
	logic                out_load;

	bvm_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.busy    (mul_busy),
		.product (mul_p)
	);

	bvm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.quotient (div_q)
	);

	// Gather the motor currents that this build sums
	assign motor_all[0] = item_q.motor_current_0;
	assign motor_all[1] = item_q.motor_current_1;
	assign motor_all[2] = item_q.motor_current_2;
	assign motor_all[3] = item_q.motor_current_3;
	assign motor_all[4] = item_q.motor_current_4;
	assign motor_all[5] = item_q.motor_current_5;
	assign motor_all[6] = item_q.motor_current_6;
	assign motor_all[7] = item_q.motor_current_7;

	for (genvar i = 0; i < MAX_MOTORS; i++) begin : g_motor
		assign motor_arr[i] = motor_all[i];
	end

	// Datapath helpers
	always_comb begin
		lim       = (motor_count_q > MCOUNT_W'(MAX_MOTORS)) ? KW'(MAX_MOTORS)
		                                                  : KW'(motor_count_q);
		sum_done  = (k_q >= lim);
		cur_sat   = (sum_q > CSUM_W'(16'hFFFF)) ? 16'hFFFF : sum_q[MA_W-1:0];
		elapsed   = item_q.now_ms - last_stamp_q;
		acc_sum   = {1'b0, acc_q} + {1'b0, add_q};
		cell_more = (j_q < CELL_W'(CELL_TOP)) &&
		            ((j_q < cells_q) || (CPROD_W'(filtered_q) > cprod_q));
		out_free  = !out_valid_q || !result_stall;
		out_load  = (state_q == ST_LOW_W) && !mul_busy && out_free;
	end

	// Issue work to the serial multiplier and divider
	always_comb begin
		mul_req = '0;
		div_req = '0;
		case (state_q)
			ST_SCALE: begin
				mul_req.start = 1'b1;
				mul_req.a     = MUL_A_W'(item_q.adc_raw);
				mul_req.b     = MUL_B_W'(SCALE_NUM);
			end
			ST_SCALE_W: begin
				if (sum_done && !mul_busy) begin
					mul_req.start    = 1'b1;
					mul_req.a        = elapsed;
					mul_req.b        = cur_sat;
					div_req.start    = 1'b1;
					div_req.dividend = mul_p[DIV_N_W-1:0];
					div_req.divisor  = DIV_D_W'(SCALE_DEN);
				end
			end
			ST_ACC: begin
				mul_req.start = 1'b1;
				mul_req.a     = MUL_A_W'(filtered_q);
				mul_req.b     = MUL_B_W'(filter_weight_q);
			end
			ST_FMUL_W: begin
				if (!mul_busy) begin
					div_req.start    = 1'b1;
					div_req.dividend = mul_p[DIV_N_W-1:0] + DIV_N_W'(sample_q);
					div_req.divisor  = {1'b0, filter_weight_q} + DIV_D_W'(1);
				end
			end
			ST_LOW: begin
				mul_req.start = 1'b1;
				mul_req.a     = MUL_A_W'(min_cell_q);
				mul_req.b     = MUL_B_W'(cells_q);
			end
			default: begin
			end
		endcase
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_weight_q <= RST_FILTER_WEIGHT;
			max_cell_q      <= RST_MAX_CELL_MV;
			min_cell_q      <= RST_MIN_CELL_MV;
			idle_q          <= RST_IDLE_CURRENT_MA;
			motor_count_q   <= RST_MOTOR_COUNT;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FILTER_WEIGHT:   filter_weight_q <= cfg_data[WEIGHT_W-1:0];
				CFG_MAX_CELL_MV:     max_cell_q      <= cfg_data[MV_W-1:0];
				CFG_MIN_CELL_MV:     min_cell_q      <= cfg_data[MV_W-1:0];
				CFG_IDLE_CURRENT_MA: idle_q          <= cfg_data[MA_W-1:0];
				CFG_MOTOR_COUNT:     motor_count_q   <= cfg_data[MCOUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer, monitor state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			item_q       <= '0;
			filtered_q   <= '0;
			cells_q      <= '0;
			last_stamp_q <= '0;
			acc_q        <= '0;
			used_q       <= '0;
			last_cur_q   <= '0;
			sum_q        <= '0;
			k_q          <= '0;
			sample_q     <= '0;
			add_q        <= '0;
			j_q          <= '0;
			cprod_q      <= '0;
			out_valid_q  <= 1'b0;
			result_q     <= '0;
		end else begin
			// Load a new result, or drop the current one once it transfers
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						item_q  <= item;
						j_q     <= '0;
						cprod_q <= '0;
						state_q <= item.func ? ST_CELL : ST_SCALE;
					end
				end
				ST_SCALE: begin
					sum_q   <= CSUM_W'(idle_q);
					k_q     <= '0;
					state_q <= ST_SCALE_W;
				end
				ST_SCALE_W: begin
					// Add one motor current per cycle
					if (!sum_done) begin
						sum_q <= sum_q + CSUM_W'(motor_arr[k_q[MIDX_W-1:0]]);
						k_q   <= k_q + 1'b1;
					end else if (!mul_busy) begin
						last_cur_q   <= cur_sat;
						last_stamp_q <= item_q.now_ms;
						state_q      <= ST_CHG_W;
					end
				end
				ST_CHG_W: begin
					if (!mul_busy && !div_busy) begin
						sample_q <= div_q[MV_W-1:0];
						add_q    <= mul_p;
						state_q  <= ST_ACC;
					end
				end
				ST_ACC: begin
					// Saturating charge accumulate
					acc_q   <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
					state_q <= ST_MAH;
				end
				ST_MAH: begin
					// Count at most one mAh per update
					if (acc_q >= ACC_W'(MAH_MAMS)) begin
						acc_q <= acc_q - ACC_W'(MAH_MAMS);
						if (used_q != '1) begin
							used_q <= used_q + 1'b1;
						end
					end
					state_q <= ST_FMUL_W;
				end
				ST_FMUL_W: begin
					if (!mul_busy) begin
						state_q <= ST_FDIV_W;
					end
				end
				ST_FDIV_W: begin
					if (!div_busy) begin
						filtered_q <= div_q[MV_W-1:0];
						state_q    <= ST_LOW;
					end
				end
				ST_CELL: begin
					// Advance the candidate count, up to 15, while it is below the old
					// count or still fails to cover the filtered voltage
					if (cell_more) begin
						j_q     <= j_q + 1'b1;
						cprod_q <= cprod_q + CPROD_W'(max_cell_q);
					end else begin
						cells_q <= j_q;
						state_q <= ST_LOW;
					end
				end
				ST_LOW: begin
					state_q <= ST_LOW_W;
				end
				ST_LOW_W: begin
					// Hold until the threshold is ready and the output frees
					if (out_load) begin
						result_q.voltage_mv  <= filtered_q;
						result_q.current_ma  <= last_cur_q;
						result_q.used_mah    <= used_q;
						result_q.cell_count  <= cells_q;
						result_q.low_battery <= (CPROD_W'(filtered_q) <
						                         mul_p[CPROD_W-1:0]);
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

endmodule

`default_nettype wire

@@ design/bvm_mul.sv @@
// ----------------------------------------------------------------------------
// bvm_mul
// Bit-serial shift-and-add multiplier. One multiplier bit per cycle, LSB
// first; finishes as soon as the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_mul import bvm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mul_req_t           req,
	output logic                    busy,
	output logic [MUL_P_W-1:0]      product
);

	logic [MUL_P_W-1:0] a_q;
	logic [MUL_B_W-1:0] b_q;
	logic [MUL_P_W-1:0] p_q;
	logic               busy_q;

	// Load operands, then add the shifted multiplicand per set bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			p_q    <= '0;
			busy_q <= 1'b0;
		end else if (req.start) begin
			a_q    <= MUL_P_W'(req.a);
			b_q    <= req.b;
			p_q    <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (b_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				if (b_q[0]) begin
					p_q <= p_q + a_q;
				end
				a_q <= {a_q[MUL_P_W-2:0], 1'b0};
				b_q <= {1'b0, b_q[MUL_B_W-1:1]};
			end
		end
	end

	assign busy    = busy_q;
	assign product = p_q;

endmodule

`default_nettype wire

@@ design/bvm_div.sv @@
// ----------------------------------------------------------------------------
// bvm_div
// Restoring radix-2 divider. One quotient bit per cycle; the quotient bits
// shift into the dividend register as the dividend bits leave it.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_div import bvm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire div_req_t           req,
	output logic                    busy,
	output logic [DIV_N_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DIV_N_W + 1);

	logic [DIV_N_W-1:0] n_q;
	logic [DIV_D_W-1:0] d_q;
	logic [DIV_D_W-1:0] r_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;

	logic [DIV_D_W:0]   trial;
	logic [DIV_D_W:0]   diff;
	logic               ge;

	// Trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		trial = {r_q, n_q[DIV_N_W-1]};
		diff  = trial - {1'b0, d_q};
		ge    = (trial >= {1'b0, d_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			d_q    <= '0;
			r_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (req.start) begin
			n_q    <= req.dividend;
			d_q    <= req.divisor;
			r_q    <= '0;
			cnt_q  <= CNT_W'(DIV_N_W);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			r_q   <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			n_q   <= {n_q[DIV_N_W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = n_q;

endmodule

`default_nettype wire

@@ design/bvm_checker.sv @@
// ----------------------------------------------------------------------------
// bvm_checker
// Port-level assertions of the battery monitor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_checker import bvm_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_stall,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	localparam logic [MV_W-1:0] VOLT_TOP = 16'd36300;

	// One request at a time: a transfer closes the input until it is done
	a_stall_after_transfer: assert property (
		@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall
	) else $error("item taken while a request is still in work");

	// The filter never leaves the range of the scaled sample
	a_voltage_range: assert property (
		@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.voltage_mv <= VOLT_TOP)
	) else $error("filtered voltage above full-scale value");

	// With no cells detected the threshold is zero
	a_no_cells_no_low: assert property (
		@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.cell_count == '0)) |-> !result.low_battery
	) else $error("low battery flagged with zero cells");

	// A stalled result holds
	a_result_hold: assert property (
		@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result))
	) else $error("stalled result changed or dropped");

endmodule

bind battery_voltage_and_charge_monitor bvm_checker u_bvm_checker (.*);

`default_nettype wire
